// ===== rtl/core/itbt_pkg.sv =====
// Package with the sizes, microcode format and control store of the balanced ternary converter.
package itbt_pkg;

   // Input width and the longest run of trits one conversion may produce.
   localparam int VALUE_WIDTH = 32;
   localparam int MAX_TRITS   = 21;

   // Derived sizes: trit counter, trit store index.
   localparam int CNT_W = $clog2(MAX_TRITS + 1);
   localparam int IDX_W = $clog2(MAX_TRITS);

   // Reciprocal of three, ceil(2^(VALUE_WIDTH+1) / 3), exact for every unsigned magnitude.
   localparam int RECIP_SHIFT = VALUE_WIDTH + 1;
   localparam logic [VALUE_WIDTH+1:0] RECIP_WIDE =
      (({2'b01, {(VALUE_WIDTH){1'b0}}} << 1) + (VALUE_WIDTH + 2)'(2)) / (VALUE_WIDTH + 2)'(3);
   localparam logic [VALUE_WIDTH:0] RECIP = RECIP_WIDE[VALUE_WIDTH:0];

   // Trit codes, two bits two's complement.
   localparam logic [1:0] TRIT_ZERO = 2'b00;
   localparam logic [1:0] TRIT_POS  = 2'b01;
   localparam logic [1:0] TRIT_NEG  = 2'b11;

   // Microprogram step addresses.
   typedef enum logic [1:0] {
      STEP_WAIT  = 2'd0,
      STEP_DIV   = 2'd1,
      STEP_DIGIT = 2'd2,
      STEP_EMIT  = 2'd3
   } step_type;

   // Branch conditions tested by the sequencer.
   typedef enum logic [1:0] {
      COND_ALWAYS   = 2'd0,
      COND_START    = 2'd1,
      COND_MORE     = 2'd2,
      COND_NOT_LAST = 2'd3
   } cond_type;

   // One control word: datapath enables, branch condition and both targets.
   typedef struct packed {
      logic     load;
      logic     div;
      logic     digit;
      logic     emit;
      cond_type cond;
      step_type jmp_true;
      step_type jmp_false;
   } ctrl_word_type;

   // Read-only control store.
   function automatic ctrl_word_type micro_rom(input step_type addr);
      ctrl_word_type w;
      w = '{load: 1'b0, div: 1'b0, digit: 1'b0, emit: 1'b0, cond: COND_ALWAYS,
            jmp_true: STEP_WAIT, jmp_false: STEP_WAIT};
      case (addr)
         STEP_WAIT: begin
            w.load      = 1'b1;
            w.cond      = COND_START;
            w.jmp_true  = STEP_DIV;
            w.jmp_false = STEP_WAIT;
         end
         STEP_DIV: begin
            w.div       = 1'b1;
            w.cond      = COND_ALWAYS;
            w.jmp_true  = STEP_DIGIT;
            w.jmp_false = STEP_DIGIT;
         end
         STEP_DIGIT: begin
            w.digit     = 1'b1;
            w.cond      = COND_MORE;
            w.jmp_true  = STEP_DIV;
            w.jmp_false = STEP_EMIT;
         end
         STEP_EMIT: begin
            w.emit      = 1'b1;
            w.cond      = COND_NOT_LAST;
            w.jmp_true  = STEP_EMIT;
            w.jmp_false = STEP_WAIT;
         end
         default: begin
            w.cond      = COND_ALWAYS;
         end
      endcase
      return w;
   endfunction

endpackage

// ===== rtl/core/int_to_balanced_ternary_core.sv =====
// Signed integer to balanced ternary converter, driven by a small microprogram.
//
// Usage: pulse start with req_value while busy is low; the transfer happens at that
// edge and busy rises on the next cycle. The block then forms the trits least
// significant first, each in a divide step (multiply the magnitude by the
// reciprocal of three and register the quotient) and a digit step (form the
// remainder, the trit and the carried quotient), and stores them. It then emits
// them most significant first, one per cycle, each on rsp_trit for exactly one
// cycle with rsp_strobe high; rsp_last_trit marks the final, least significant trit.
// A conversion yields 1 to 21 trits. Busy stays high through the divide, digit and
// emit steps, so the block takes no new value before the last trit of the previous
// one is emitted. Each trit passes through the single divide-by-three multiplier.
// Zero yields a single 0 trit. The most negative input converts exactly.
// Reset returns the sequencer to its wait step and drops rsp_strobe at once.
// The receiver cannot stall: every strobed result is taken in its cycle.
module int_to_balanced_ternary_core (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   start,
   output logic                                   busy,
   input  logic signed [itbt_pkg::VALUE_WIDTH-1:0] req_value,
   output logic                                   rsp_strobe,
   output logic signed [1:0]                      rsp_trit,
   output logic                                   rsp_last_trit
);
   import itbt_pkg::*;

   // Sequencer and datapath registers.
   step_type                  upc_ff, upc_in;
   logic [VALUE_WIDTH-1:0]    mag_ff, mag_in;
   logic [VALUE_WIDTH-1:0]    quot_ff, quot_in;
   logic                      neg_ff, neg_in;
   logic [CNT_W-1:0]          count_ff, count_in;
   logic [1:0]                store_ff [MAX_TRITS];
   logic                      strobe_ff, strobe_in;
   logic [1:0]                trit_ff, trit_in;
   logic                      last_ff, last_in;

   // Combinational datapath values.
   ctrl_word_type             ctrl;
   logic                      cond_true;
   logic [2*VALUE_WIDTH:0]    product;
   logic [VALUE_WIDTH-1:0]    triple;
   logic [VALUE_WIDTH-1:0]    diff;
   logic [1:0]                rem;
   logic                      carry;
   logic [1:0]                digit;
   logic [1:0]                digit_signed;
   logic [VALUE_WIDTH-1:0]    mag_next;
   logic [CNT_W-1:0]          count_inc;
   logic [CNT_W-1:0]          count_dec;
   logic [IDX_W-1:0]          wr_idx;
   logic [IDX_W-1:0]          rd_idx;

   // Fetch the control word of the current step.
   assign ctrl = micro_rom(upc_ff);
   assign busy = (upc_ff != STEP_WAIT);

   // Divide by three: reciprocal multiply, then remainder from the registered quotient.
   assign product      = {{VALUE_WIDTH{1'b0}}, mag_ff} * {{VALUE_WIDTH{1'b0}}, RECIP};
   assign triple       = {quot_ff[VALUE_WIDTH-2:0], 1'b0} + quot_ff;
   assign diff         = mag_ff - triple;
   assign rem          = diff[1:0];
   assign carry        = (rem == 2'd2);
   assign mag_next     = quot_ff + {{(VALUE_WIDTH-1){1'b0}}, carry};
   assign digit        = carry ? TRIT_NEG : ((rem == 2'd1) ? TRIT_POS : TRIT_ZERO);
   assign digit_signed = neg_ff ? (~digit + 2'd1) : digit;

   // Counter arithmetic and store addresses.
   assign count_inc = count_ff + CNT_W'(1);
   assign count_dec = count_ff - CNT_W'(1);
   assign wr_idx    = count_ff[IDX_W-1:0];
   assign rd_idx    = count_dec[IDX_W-1:0];

   // Branch condition selected by the control word.
   always_comb begin
      case (ctrl.cond)
         COND_ALWAYS:   cond_true = 1'b1;
         COND_START:    cond_true = start;
         COND_MORE:     cond_true = (mag_next != '0) && (count_inc < CNT_W'(MAX_TRITS));
         COND_NOT_LAST: cond_true = (count_ff != CNT_W'(1));
         default:       cond_true = 1'b0;
      endcase
   end

   // Next step of the microprogram.
   always_comb begin
      upc_in = cond_true ? ctrl.jmp_true : ctrl.jmp_false;
   end

   // Datapath updates driven by the control word.
   always_comb begin
      mag_in    = mag_ff;
      quot_in   = quot_ff;
      neg_in    = neg_ff;
      count_in  = count_ff;
      strobe_in = 1'b0;
      trit_in   = trit_ff;
      last_in   = last_ff;
      if (ctrl.load && start) begin
         neg_in   = req_value[VALUE_WIDTH-1];
         mag_in   = req_value[VALUE_WIDTH-1] ? (~req_value + VALUE_WIDTH'(1)) : req_value;
         count_in = '0;
      end
      if (ctrl.div) begin
         quot_in = product[RECIP_SHIFT +: VALUE_WIDTH];
      end
      if (ctrl.digit) begin
         mag_in   = mag_next;
         count_in = count_inc;
      end
      if (ctrl.emit) begin
         strobe_in = 1'b1;
         trit_in   = store_ff[rd_idx];
         last_in   = (count_ff == CNT_W'(1));
         count_in  = count_dec;
      end
   end

   // Control registers with reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         upc_ff    <= STEP_WAIT;
         strobe_ff <= 1'b0;
         count_ff  <= '0;
         neg_ff    <= 1'b0;
      end else begin
         upc_ff    <= upc_in;
         strobe_ff <= strobe_in;
         count_ff  <= count_in;
         neg_ff    <= neg_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      mag_ff  <= mag_in;
      quot_ff <= quot_in;
      trit_ff <= trit_in;
      last_ff <= last_in;
      if (ctrl.digit) begin
         store_ff[wr_idx] <= digit_signed;
      end
   end

   // Result ports.
   assign rsp_strobe    = strobe_ff;
   assign rsp_trit      = trit_ff;
   assign rsp_last_trit = last_ff;

endmodule

// ===== bench/tb_int_to_balanced_ternary_core.sv =====
// Self-checking testbench for the balanced ternary converter core.
`timescale 1ns / 1ps

module tb_int_to_balanced_ternary_core;
   import itbt_pkg::*;

   localparam int CYCLE_LIMIT = 300000;
   localparam int DRAIN_CYCLES = 80;
   localparam int DIRECTED_ROWS = 25;
   localparam int RANDOM_ITEMS = 85;

   // One emitted digit as the core presents it.
   typedef struct {
      logic signed [1:0] trit;
      logic              last_trit;
   } ternary_digit_type;

   logic                          clock;
   logic                          reset;
   logic                          start;
   logic                          busy;
   logic signed [VALUE_WIDTH-1:0] req_value;
   logic                          rsp_strobe;
   logic signed [1:0]             rsp_trit;
   logic                          rsp_last_trit;

   ternary_digit_type trits_due[$];
   string             typed_digits;
   int                error_count;
   int                cycle_count;

   // Directed rows: a digit string ('+', '0', '-') is the known answer, an empty
   // string leaves the row to the converter model below.
   logic signed [VALUE_WIDTH-1:0] row_value [DIRECTED_ROWS] = '{
      32'sd0, 32'sd1, -32'sd1, 32'sd2, -32'sd2, 32'sd3, 32'sd4, 32'sd5, -32'sd5,
      32'sd13, 32'sd1743392200, -32'sd1743392200, 32'sd1743392201, -32'sd1743392201,
      32'sh7FFFFFFF, -32'sh7FFFFFFF, 32'sh80000000, 32'sh55555555, 32'shAAAAAAAA,
      32'sd6, 32'sd7, -32'sd8, 32'sd100, 32'sd1162261467, -32'sd1162261467
   };
   string row_digits [DIRECTED_ROWS] = '{
      "0", "+", "-", "+-", "-+", "+0", "++", "+--", "-++",
      "+++", "++++++++++++++++++++", "--------------------",
      "+--------------------", "-++++++++++++++++++++",
      "", "", "", "", "", "", "", "", "", "", ""
   };

   int_to_balanced_ternary_core i_dut (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_value     (req_value),
      .rsp_strobe    (rsp_strobe),
      .rsp_trit      (rsp_trit),
      .rsp_last_trit (rsp_last_trit)
   );

   // Free-running clock, 2 ns period.
   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Converter model: divide the unsigned magnitude by three, fold a remainder
   // of two into a negative digit with a carry, and flip every digit for a
   // negative input. Digits are queued most significant first.
   function automatic void convert_to_trits(input logic signed [VALUE_WIDTH-1:0] value);
      logic [VALUE_WIDTH-1:0] mag_in;
      logic [63:0]            mag;
      logic [63:0]            rem;
      logic signed [1:0]      digits [MAX_TRITS];
      logic signed [1:0]      d;
      logic                   negative;
      int                     count;
      ternary_digit_type      item;
      negative = value[VALUE_WIDTH-1];
      mag_in = negative ? (~value + 1'b1) : value;
      mag = 64'(mag_in);
      count = 0;
      do begin
         rem = mag % 3;
         mag = mag / 3;
         if (rem == 2) begin
            d = TRIT_NEG;
            mag = mag + 1;
         end else begin
            d = (rem == 1) ? TRIT_POS : TRIT_ZERO;
         end
         if (negative) d = -d;
         digits[count] = d;
         count++;
      end while (mag != 0 && count < MAX_TRITS);
      for (int idx = count - 1; idx >= 0; idx--) begin
         item.trit = digits[idx];
         item.last_trit = (idx == 0);
         trits_due.push_back(item);
      end
   endfunction

   // Queue a typed digit string, most significant character first.
   function automatic void queue_typed_digits(input string digits);
      ternary_digit_type item;
      for (int k = 0; k < digits.len(); k++) begin
         case (digits[k])
            "+":     item.trit = TRIT_POS;
            "-":     item.trit = TRIT_NEG;
            default: item.trit = TRIT_ZERO;
         endcase
         item.last_trit = (k == digits.len() - 1);
         trits_due.push_back(item);
      end
   endfunction

   // Record expectations on each input transfer and check each strobed digit.
   always @(posedge clock) begin
      ternary_digit_type want;
      if (!reset) begin
         if (start && !busy) begin
            if (typed_digits.len() != 0) queue_typed_digits(typed_digits);
            else convert_to_trits(req_value);
         end
         if (rsp_strobe) begin
            if (trits_due.size() == 0) begin
               $error("unexpected digit: trit %0d last_trit %0b", rsp_trit, rsp_last_trit);
               error_count++;
            end else begin
               want = trits_due.pop_front();
               if (rsp_trit !== want.trit) begin
                  $error("trit: expected %0d, got %0d", want.trit, rsp_trit);
                  error_count++;
               end
               if (rsp_last_trit !== want.last_trit) begin
                  $error("last_trit: expected %0b, got %0b", want.last_trit, rsp_last_trit);
                  error_count++;
               end
            end
         end
      end
   end

   // Watchdog on the total run length.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   // Hold one value on the request port until its transfer, dropping start on
   // random cycles at the given percentage and scrambling the value meanwhile.
   // The typed answer changes only at a falling edge, away from the sampling edge.
   task automatic send_value(input logic signed [VALUE_WIDTH-1:0] value,
                             input string digits, input int idle_pct);
      do begin
         @(negedge clock);
         typed_digits = digits;
         if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            req_value <= $urandom;
         end else begin
            start <= 1'b1;
            req_value <= value;
         end
         @(posedge clock);
      end while (!(start && !busy));
   endtask

   // Stimulus: reset, directed table, then random values over idling phases.
   initial begin
      int                            idle_plan [4];
      int                            kind;
      int                            sign_draw;
      logic signed [VALUE_WIDTH-1:0] value;
      logic [VALUE_WIDTH-1:0]        power;
      idle_plan = '{0, 55, 0, 23};
      error_count = 0;
      cycle_count = 0;
      typed_digits = "";
      reset = 1'b1;
      start = 1'b0;
      req_value = '0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // The core must come out of reset idle and silent.
      @(posedge clock);
      if (busy !== 1'b0) begin
         $error("busy: expected 0, got %0b", busy);
         error_count++;
      end
      if (rsp_strobe !== 1'b0) begin
         $error("rsp_strobe: expected 0, got %0b", rsp_strobe);
         error_count++;
      end

      for (int row = 0; row < DIRECTED_ROWS; row++)
         send_value(row_value[row], row_digits[row], 0);

      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         kind = $urandom_range(9);
         sign_draw = $urandom_range(1);
         if (kind <= 4) begin
            value = $urandom;
         end else if (kind == 5) begin
            value = $urandom_range(40);
            if (sign_draw != 0) value = -value;
         end else if (kind == 6) begin
            value = sign_draw ? (32'sh80000000 + $urandom_range(20))
                              : (32'sh7FFFFFFF - $urandom_range(20));
         end else if (kind == 7) begin
            // Neighbors of a power of three, from one below to one above.
            power = 1;
            repeat ($urandom_range(19)) power = power * 3;
            value = $signed(power) + $urandom_range(2) - 1;
            if (sign_draw != 0) value = -value;
         end else begin
            value = $signed({{16{1'b0}}, 16'($urandom)});
            if (sign_draw != 0) value = -value;
         end
         send_value(value, "", idle_plan[(n * 4) / RANDOM_ITEMS]);
      end
      @(negedge clock);
      start <= 1'b0;

      // Drain the outstanding digits, then allow the core to settle.
      while (trits_due.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (trits_due.size() != 0) begin
         $error("%0d expected digits never arrived", trits_due.size());
         error_count++;
      end

      if (error_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
